/* rtl/dictionary_word_compressor_defines.svh */
// assertion helpers shared by the compressor blocks
`ifndef DICTIONARY_WORD_COMPRESSOR_DEFINES_SVH
`define DICTIONARY_WORD_COMPRESSOR_DEFINES_SVH

// implication checked on every clock outside reset
`define DWC_ASSERT_IMPL(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("dwc assertion failed");

// plain invariant checked on every clock outside reset
`define DWC_ASSERT_HOLD(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("dwc invariant failed");

`endif

/* rtl/dwc_pkg.sv */
package dwc_pkg;

    localparam int DATA_W       = 8;
    localparam int WINDOW_BYTES = 9;
    localparam int LONGEST_WORD = 9;
    localparam int WORD_COUNT   = 27;
    localparam int LEN_W        = 4;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [DATA_W-1:0] MARK_DICT = 8'hD0;
    localparam logic [DATA_W-1:0] ESCAPE    = 8'hFF;
    localparam logic [DATA_W-1:0] CASE_GAP  = 8'd32;
    localparam logic [DATA_W-1:0] LOWER_A   = 8'h61;
    localparam logic [DATA_W-1:0] LOWER_Z   = 8'h7A;

    // one queued transaction, already classified by the front
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              packet_end;
        logic              need_marker;
    } t_dwc_item;

    function automatic logic [DATA_W-1:0] fold(input logic [DATA_W-1:0] c);
        logic [DATA_W-1:0] r;
        r = c;
        if (c >= LOWER_A && c <= LOWER_Z) begin
            r = c - CASE_GAP;
        end
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] word_len(input int idx);
        logic [LEN_W-1:0] l;
        case (idx)
            0:       l = 4'd3;
            1:       l = 4'd4;
            2:       l = 4'd2;
            3:       l = 4'd3;
            4:       l = 4'd2;
            5:       l = 4'd8;
            6:       l = 4'd7;
            7:       l = 4'd3;
            8:       l = 4'd5;
            9:       l = 4'd4;
            10:      l = 4'd6;
            11:      l = 4'd7;
            12:      l = 4'd4;
            13:      l = 4'd5;
            14:      l = 4'd9;
            15:      l = 4'd7;
            16:      l = 4'd5;
            17:      l = 4'd5;
            18:      l = 4'd5;
            19:      l = 4'd5;
            20:      l = 4'd5;
            21:      l = 4'd4;
            22:      l = 4'd4;
            23:      l = 4'd4;
            24:      l = 4'd5;
            25:      l = 4'd4;
            26:      l = 4'd3;
            default: l = '0;
        endcase
        return l;
    endfunction

    // text is right aligned: first character sits in the highest used byte
    function automatic logic [8*LONGEST_WORD-1:0] word_text(input int idx);
        logic [8*LONGEST_WORD-1:0] t;
        case (idx)
            0:       t = "SOS";
            1:       t = "HELP";
            2:       t = "OK";
            3:       t = "YES";
            4:       t = "NO";
            5:       t = "POSITION";
            6:       t = "BATTERY";
            7:       t = "LOW";
            8:       t = "CHECK";
            9:       t = "SAFE";
            10:      t = "MOVING";
            11:      t = "STOPPED";
            12:      t = "CAMP";
            13:      t = "WATER";
            14:      t = "EMERGENCY";
            15:      t = "WEATHER";
            16:      t = "CLEAR";
            17:      t = "STORM";
            18:      t = "TRAIL";
            19:      t = "NORTH";
            20:      t = "SOUTH";
            21:      t = "EAST";
            22:      t = "WEST";
            23:      t = "COPY";
            24:      t = "ROGER";
            25:      t = "OVER";
            26:      t = "OUT";
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

/* rtl/dictionary_word_compressor.sv */
// Dictionary word compressor: takes one packet byte per transaction and emits the
// compressed stream one byte per transaction, opening each packet with marker 0xD0,
// replacing the first matching word of the fixed 27-word table (case-insensitive)
// by 0xFF and its code, and sending other bytes as literals with 0xFF doubled.
// A two-entry queue sits between the input side and the encoder, so input is taken
// while a result waits at the output. For every byte the encoder fetches from the
// queue, emits its output bytes and then makes a final window check that finds
// nothing left to decide; it makes one decision per cycle and its output register
// moves one byte per cycle, both while the output is not stalled; a packet's final
// byte drains the lookahead window and may produce up to 18 bytes. packet_done marks
// the last byte of a packet and run_last the last byte caused by one input transaction.
module dictionary_word_compressor #(
    parameter int WINDOW_BYTES = dwc_pkg::WINDOW_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_packet_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_code_byte,
    output logic       o_packet_done,
    output logic       o_run_last
);

    dwc_pkg::t_dwc_item w_front_item;
    dwc_pkg::t_dwc_item w_back_item;
    logic               w_front_valid;
    logic               w_front_ready;
    logic               w_back_valid;
    logic               w_back_ready;

    dwc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_packet_end (i_packet_end),
        .o_item_valid (w_front_valid),
        .i_item_ready (w_front_ready),
        .o_item       (w_front_item)
    );

    dwc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push_item  (w_front_item),
        .o_pop_valid  (w_back_valid),
        .i_pop_ready  (w_back_ready),
        .o_pop_item   (w_back_item)
    );

    dwc_back #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (w_back_valid),
        .o_item_ready  (w_back_ready),
        .i_item        (w_back_item),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_code_byte   (o_code_byte),
        .o_packet_done (o_packet_done),
        .o_run_last    (o_run_last)
    );

endmodule

/* rtl/dwc_front.sv */
module dwc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_packet_end,
    output logic                o_item_valid,
    input  logic                i_item_ready,
    output dwc_pkg::t_dwc_item  o_item
);

    logic r_marker_sent;
    logic n_marker_sent;
    logic w_accept;

    assign o_ready      = i_item_ready;
    assign o_item_valid = i_valid;
    assign w_accept     = i_valid && i_item_ready;

    always_comb begin
        o_item.data_byte   = i_data_byte;
        o_item.packet_end  = i_packet_end;
        o_item.need_marker = !r_marker_sent;
        n_marker_sent      = r_marker_sent;
        if (w_accept) begin
            // a packet end rearms the marker for the next packet
            n_marker_sent = !i_packet_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker_sent <= 1'b0;
        end else begin
            r_marker_sent <= n_marker_sent;
        end
    end

endmodule

/* rtl/dwc_queue.sv */
`include "dictionary_word_compressor_defines.svh"

module dwc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_valid,
    output logic                o_push_ready,
    input  dwc_pkg::t_dwc_item  i_push_item,
    output logic                o_pop_valid,
    input  logic                i_pop_ready,
    output dwc_pkg::t_dwc_item  o_pop_item
);

    localparam int PTR_W = $clog2(dwc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dwc_pkg::QUEUE_DEPTH + 1);

    dwc_pkg::t_dwc_item r_mem [dwc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = (r_count != CNT_W'(dwc_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(dwc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(dwc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `DWC_ASSERT_HOLD(a_queue_bound, r_count <= CNT_W'(dwc_pkg::QUEUE_DEPTH))

endmodule

/* rtl/dwc_back.sv */
`include "dictionary_word_compressor_defines.svh"

module dwc_back #(
    parameter int WINDOW_BYTES = dwc_pkg::WINDOW_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    output logic                o_item_ready,
    input  dwc_pkg::t_dwc_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_code_byte,
    output logic                o_packet_done,
    output logic                o_run_last
);

    localparam int FILL_W = $clog2(WINDOW_BYTES + 1);
    localparam int IDX_W  = $clog2(WINDOW_BYTES);
    localparam int LEN_W  = dwc_pkg::LEN_W;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_RUN    = 3'b010,
        S_SECOND = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [7:0]        r_win [WINDOW_BYTES];
    logic [7:0]        n_win [WINDOW_BYTES];
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_mark, n_mark;
    logic              r_end, n_end;
    logic [7:0]        r_second, n_second;
    logic              r_pend_last, n_pend_last;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_byte, n_out_byte;
    logic              r_out_done, n_out_done;
    logic              r_out_last, n_out_last;

    logic                           w_slot;
    logic                           w_need_dec;
    logic [dwc_pkg::WORD_COUNT-1:0] w_match;
    logic                           w_hit;
    logic [7:0]                     w_code;
    logic [LEN_W-1:0]               w_take;
    logic [FILL_W-1:0]              w_rest;
    logic                           w_rest_last;
    logic [8*dwc_pkg::LONGEST_WORD-1:0] w_text;
    logic [LEN_W-1:0]               w_wlen;

    assign o_valid       = r_out_valid;
    assign o_code_byte   = r_out_byte;
    assign o_packet_done = r_out_done;
    assign o_run_last    = r_out_last;

    assign w_slot       = !r_out_valid || i_ready;
    assign o_item_ready = (r_state == S_IDLE);
    assign w_need_dec   = r_end ? (r_fill != '0)
                                : (r_fill == FILL_W'(dwc_pkg::LONGEST_WORD));

    // match every word against the window head in parallel
    always_comb begin
        w_text = '0;
        w_wlen = '0;
        for (int d = 0; d < dwc_pkg::WORD_COUNT; d++) begin
            w_text     = dwc_pkg::word_text(d);
            w_wlen     = dwc_pkg::word_len(d);
            w_match[d] = (FILL_W'(w_wlen) <= r_fill);
            for (int c = 0; c < dwc_pkg::LONGEST_WORD; c++) begin
                if (c < int'(w_wlen)) begin
                    if (dwc_pkg::fold(r_win[c]) != w_text[(int'(w_wlen) - 1 - c) * 8 +: 8]) begin
                        w_match[d] = 1'b0;
                    end
                end
            end
        end
    end

    // first word in table order wins
    always_comb begin
        w_hit  = 1'b0;
        w_code = '0;
        w_take = LEN_W'(1);
        for (int d = dwc_pkg::WORD_COUNT - 1; d >= 0; d--) begin
            if (w_match[d]) begin
                w_hit  = 1'b1;
                w_code = 8'(d + 1);
                w_take = dwc_pkg::word_len(d);
            end
        end
    end

    assign w_rest      = r_fill - FILL_W'(w_take);
    assign w_rest_last = !r_end || (w_rest == '0);

    always_comb begin
        n_state     = r_state;
        n_win       = r_win;
        n_fill      = r_fill;
        n_mark      = r_mark;
        n_end       = r_end;
        n_second    = r_second;
        n_pend_last = r_pend_last;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_done  = r_out_done;
        n_out_last  = r_out_last;

        if (w_slot) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_win[r_fill[IDX_W-1:0]] = i_item.data_byte;
                    n_fill  = r_fill + 1'b1;
                    n_mark  = i_item.need_marker;
                    n_end   = i_item.packet_end;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_slot) begin
                    if (r_mark) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = dwc_pkg::MARK_DICT;
                        n_out_last  = !w_need_dec;
                        n_out_done  = 1'b0;
                        n_mark      = 1'b0;
                    end else if (w_need_dec) begin
                        n_fill = w_rest;
                        for (int i = 0; i < WINDOW_BYTES; i++) begin
                            for (int k = 1; k <= dwc_pkg::LONGEST_WORD; k++) begin
                                if (int'(w_take) == k && i + k < WINDOW_BYTES) begin
                                    n_win[i] = r_win[i + k];
                                end
                            end
                        end
                        n_out_valid = 1'b1;
                        if (w_hit || r_win[0] == dwc_pkg::ESCAPE) begin
                            n_out_byte  = dwc_pkg::ESCAPE;
                            n_out_last  = 1'b0;
                            n_out_done  = 1'b0;
                            n_second    = w_hit ? w_code : dwc_pkg::ESCAPE;
                            n_pend_last = w_rest_last;
                            n_state     = S_SECOND;
                        end else begin
                            n_out_byte = r_win[0];
                            n_out_last = w_rest_last;
                            n_out_done = r_end && w_rest_last;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SECOND: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_second;
                    n_out_last  = r_pend_last;
                    n_out_done  = r_end && r_pend_last;
                    n_state     = S_RUN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_win       <= n_win;
        r_end       <= n_end;
        r_second    <= n_second;
        r_pend_last <= n_pend_last;
        r_out_byte  <= n_out_byte;
        r_out_done  <= n_out_done;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_mark      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_mark      <= n_mark;
            r_out_valid <= n_out_valid;
        end
    end

    `DWC_ASSERT_HOLD(a_fill_bound, r_fill <= FILL_W'(dwc_pkg::LONGEST_WORD))
    `DWC_ASSERT_IMPL(a_second_behind_first, r_state == S_SECOND, r_out_valid)
    `DWC_ASSERT_IMPL(a_marker_first, r_mark, r_fill == FILL_W'(1))
    `DWC_ASSERT_IMPL(a_done_is_last, r_out_valid && r_out_done, r_out_last)

endmodule
